/* hdl/lbp_contrast_3x3_defines.svh */
// Assertion macros for the LBP/C block.
// Uses the clk and rst names of the module that takes this header.
`ifndef LBP_CONTRAST_3X3_DEFINES_SVH
`define LBP_CONTRAST_3X3_DEFINES_SVH

`ifndef SYNTHESIS
`define LBPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lbp_contrast_3x3 assertion failed");
`define LBPC_ASSERT_IMPL(lbl, pre, post) \
  `LBPC_ASSERT(lbl, (pre) |-> (post))
`else
`define LBPC_ASSERT(lbl, prop)
`define LBPC_ASSERT_IMPL(lbl, pre, post)
`endif

`endif

/* hdl/lbpc_pkg.sv */
// Shared types, widths and reciprocal table of the LBP/C block.
// No dependencies.
package lbpc_pkg;

  localparam int PIXEL_BITS  = 8;
  localparam int PIX_W       = 8;
  localparam int NBR         = 8;
  localparam int SUM_W       = PIX_W + 3;
  localparam int CNT_W       = 4;
  localparam int FRAC_BITS   = 8;
  localparam int NUM_W       = SUM_W + FRAC_BITS;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int MEAN_W      = 17;
  localparam int CONTRAST_W  = 16;

  localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((1 << PIXEL_BITS) - 1);
  localparam logic [CONTRAST_W-1:0] CONTRAST_MAX = '1;

  typedef struct packed {
    logic [PIX_W-1:0] center_pixel;
    logic [PIX_W-1:0] pix_top_left;
    logic [PIX_W-1:0] pix_top;
    logic [PIX_W-1:0] pix_top_right;
    logic [PIX_W-1:0] pix_left;
    logic [PIX_W-1:0] pix_right;
    logic [PIX_W-1:0] pix_bottom_left;
    logic [PIX_W-1:0] pix_bottom;
    logic [PIX_W-1:0] pix_bottom_right;
  } win_t;

  typedef struct packed {
    logic [PIX_W-1:0]      lbp_code;
    logic [CONTRAST_W-1:0] contrast_q8;
  } result_t;

  // ceil(2^24 / count), exact floor division for numerators below 2^19
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] r;
    unique case (count)
      4'd1:    r = 25'd16777216;
      4'd2:    r = 25'd8388608;
      4'd3:    r = 25'd5592406;
      4'd4:    r = 25'd4194304;
      4'd5:    r = 25'd3355444;
      4'd6:    r = 25'd2796203;
      4'd7:    r = 25'd2396746;
      4'd8:    r = 25'd2097152;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/lbp_contrast_3x3.sv */
// LBP/C top level: four-stage pipeline from 3x3 window to code and contrast.
// Depends on lbpc_pkg and lbp_contrast_3x3_defines.svh.
//
// One window beat is accepted per cycle while window_ready is high. Its result
// passes through every register stage in order. The four register stages are
// compare, group sums and counts, reciprocal multiply for each group mean, then
// difference into the output register. The pipeline advances as a whole whenever
// the output register is empty or being taken. The sustained rate is one window
// per cycle while result_ready stays high.
`include "lbp_contrast_3x3_defines.svh"

module lbp_contrast_3x3 (
  input  logic             clk,
  input  logic             rst,
  input  logic             window_valid,
  output logic             window_ready,
  input  lbpc_pkg::win_t   window,
  output logic             result_valid,
  input  logic             result_ready,
  output lbpc_pkg::result_t result
);

  logic en;
  logic [lbpc_pkg::PIX_W-1:0] nbr [lbpc_pkg::NBR];
  logic [lbpc_pkg::PIX_W-1:0] center;

  logic                       v1;
  logic [lbpc_pkg::PIX_W-1:0] s1_code;
  logic [lbpc_pkg::PIX_W-1:0] s1_hi [lbpc_pkg::NBR];
  logic [lbpc_pkg::PIX_W-1:0] s1_lo [lbpc_pkg::NBR];

  logic                       v2;
  logic [lbpc_pkg::PIX_W-1:0] s2_code;
  logic [lbpc_pkg::SUM_W-1:0] s2_sum_hi, s2_sum_lo;
  logic [lbpc_pkg::CNT_W-1:0] s2_cnt_hi, s2_cnt_lo;
  logic [lbpc_pkg::SUM_W-1:0] sum_hi_next, sum_lo_next;
  logic [lbpc_pkg::CNT_W-1:0] cnt_hi_next;

  logic                        v3;
  logic [lbpc_pkg::PIX_W-1:0]  s3_code;
  logic [lbpc_pkg::MEAN_W-1:0] s3_mean_hi, s3_mean_lo;
  logic                        s3_has_hi, s3_has_lo;
  logic [lbpc_pkg::PROD_W-1:0] prod_hi, prod_lo;

  logic [lbpc_pkg::MEAN_W-1:0] contrast_wide;

  assign en           = !result_valid || result_ready;
  assign window_ready = en;

  assign center = window.center_pixel & lbpc_pkg::PIX_MASK;
  assign nbr[0] = window.pix_top_left     & lbpc_pkg::PIX_MASK;
  assign nbr[1] = window.pix_top          & lbpc_pkg::PIX_MASK;
  assign nbr[2] = window.pix_top_right    & lbpc_pkg::PIX_MASK;
  assign nbr[3] = window.pix_left         & lbpc_pkg::PIX_MASK;
  assign nbr[4] = window.pix_right        & lbpc_pkg::PIX_MASK;
  assign nbr[5] = window.pix_bottom_left  & lbpc_pkg::PIX_MASK;
  assign nbr[6] = window.pix_bottom       & lbpc_pkg::PIX_MASK;
  assign nbr[7] = window.pix_bottom_right & lbpc_pkg::PIX_MASK;

  // compare and split into groups
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= window_valid;
    end
    if (en) begin
      for (int k = 0; k < lbpc_pkg::NBR; k++) begin
        s1_code[k] <= (nbr[k] >= center);
        s1_hi[k]   <= (nbr[k] >= center) ? nbr[k] : '0;
        s1_lo[k]   <= (nbr[k] >= center) ? '0 : nbr[k];
      end
    end
  end

  always_comb begin
    sum_hi_next = '0;
    sum_lo_next = '0;
    cnt_hi_next = '0;
    for (int k = 0; k < lbpc_pkg::NBR; k++) begin
      sum_hi_next = sum_hi_next + lbpc_pkg::SUM_W'(s1_hi[k]);
      sum_lo_next = sum_lo_next + lbpc_pkg::SUM_W'(s1_lo[k]);
      cnt_hi_next = cnt_hi_next + lbpc_pkg::CNT_W'(s1_code[k]);
    end
  end

  // group sums and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      s2_code   <= s1_code;
      s2_sum_hi <= sum_hi_next;
      s2_sum_lo <= sum_lo_next;
      s2_cnt_hi <= cnt_hi_next;
      s2_cnt_lo <= lbpc_pkg::CNT_W'(lbpc_pkg::NBR) - cnt_hi_next;
    end
  end

  assign prod_hi = lbpc_pkg::PROD_W'({s2_sum_hi, {lbpc_pkg::FRAC_BITS{1'b0}}})
                 * lbpc_pkg::PROD_W'(lbpc_pkg::recip(s2_cnt_hi));
  assign prod_lo = lbpc_pkg::PROD_W'({s2_sum_lo, {lbpc_pkg::FRAC_BITS{1'b0}}})
                 * lbpc_pkg::PROD_W'(lbpc_pkg::recip(s2_cnt_lo));

  // group means
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      s3_code    <= s2_code;
      s3_mean_hi <= prod_hi[lbpc_pkg::RECIP_SHIFT +: lbpc_pkg::MEAN_W];
      s3_mean_lo <= prod_lo[lbpc_pkg::RECIP_SHIFT +: lbpc_pkg::MEAN_W];
      s3_has_hi  <= (s2_cnt_hi != '0);
      s3_has_lo  <= (s2_cnt_lo != '0);
    end
  end

  always_comb begin
    priority if (s3_has_hi && s3_has_lo) begin
      contrast_wide = s3_mean_hi - s3_mean_lo;
    end else if (s3_has_hi) begin
      contrast_wide = s3_mean_hi;
    end else begin
      contrast_wide = s3_mean_lo;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= v3;
    end
    if (en) begin
      result.lbp_code    <= s3_code;
      result.contrast_q8 <= (contrast_wide > lbpc_pkg::MEAN_W'(lbpc_pkg::CONTRAST_MAX))
                            ? lbpc_pkg::CONTRAST_MAX
                            : contrast_wide[lbpc_pkg::CONTRAST_W-1:0];
    end
  end

  `LBPC_ASSERT(a_accept_enters, (window_valid && window_ready) |=> v1)
  `LBPC_ASSERT_IMPL(a_empty_group_sum, v2 && (s2_cnt_hi == '0), s2_sum_hi == '0)
  `LBPC_ASSERT_IMPL(a_mean_order, v3 && s3_has_hi && s3_has_lo, s3_mean_lo < s3_mean_hi)

endmodule

/* tb/sv/lbp_contrast_3x3_tb.sv */
// Self-checking testbench for lbp_contrast_3x3: windows in, LBP code and contrast out.
// Predicts each result in SystemVerilog and compares beats in order; uses lbpc_pkg.
`timescale 1ns / 1ps

module lbp_contrast_3x3_tb;

  localparam int IDLE_PCT = 11;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              window_valid = 1'b0;
  logic              window_ready;
  lbpc_pkg::win_t    window = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  lbpc_pkg::result_t result;

  lbpc_pkg::result_t pending_results[$];
  int                mismatches = 0;
  bit                steady = 1'b0;

  lbp_contrast_3x3 i_dut (
    .clk          (clk),
    .rst          (rst),
    .window_valid (window_valid),
    .window_ready (window_ready),
    .window       (window),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic lbpc_pkg::result_t lbpc_expected(input lbpc_pkg::win_t w);
    logic [lbpc_pkg::PIX_W-1:0] nbr [lbpc_pkg::NBR];
    logic [lbpc_pkg::PIX_W-1:0] ctr;
    int unsigned sum_hi, sum_lo, cnt_hi, cnt_lo, mean_hi, mean_lo, contrast;
    lbpc_pkg::result_t r;
    r = '0;
    sum_hi = 0;
    sum_lo = 0;
    cnt_hi = 0;
    cnt_lo = 0;
    ctr = w.center_pixel & lbpc_pkg::PIX_MASK;
    nbr = '{w.pix_top_left, w.pix_top, w.pix_top_right, w.pix_left,
            w.pix_right, w.pix_bottom_left, w.pix_bottom, w.pix_bottom_right};
    for (int k = 0; k < lbpc_pkg::NBR; k++) begin
      if ((nbr[k] & lbpc_pkg::PIX_MASK) >= ctr) begin
        r.lbp_code[k] = 1'b1;
        sum_hi += 32'(nbr[k] & lbpc_pkg::PIX_MASK);
        cnt_hi++;
      end else begin
        sum_lo += 32'(nbr[k] & lbpc_pkg::PIX_MASK);
        cnt_lo++;
      end
    end
    mean_hi = (cnt_hi != 0) ? (sum_hi << lbpc_pkg::FRAC_BITS) / cnt_hi : 0;
    mean_lo = (cnt_lo != 0) ? (sum_lo << lbpc_pkg::FRAC_BITS) / cnt_lo : 0;
    if (cnt_hi != 0 && cnt_lo != 0) begin
      contrast = mean_hi - mean_lo;
    end else if (cnt_hi != 0) begin
      contrast = mean_hi;
    end else begin
      contrast = mean_lo;
    end
    if (contrast > 32'hFFFF) begin
      contrast = 32'hFFFF;
    end
    r.contrast_q8 = contrast[lbpc_pkg::CONTRAST_W-1:0];
    return r;
  endfunction

  function automatic lbpc_pkg::win_t uniform_window(input int ctr, input int nbr);
    lbpc_pkg::win_t w;
    w.center_pixel = lbpc_pkg::PIX_W'(ctr);
    for (int k = 0; k < lbpc_pkg::NBR; k++) begin
      w[(lbpc_pkg::NBR-1-k)*lbpc_pkg::PIX_W +: lbpc_pkg::PIX_W] = lbpc_pkg::PIX_W'(nbr);
    end
    return w;
  endfunction

  // mode 0: any values; mode 1: neighbors close to the center; mode 2: extreme center
  function automatic lbpc_pkg::win_t random_window(input int mode);
    lbpc_pkg::win_t w;
    int   ctr, v;
    w = '0;
    case (mode)
      1: ctr = int'($urandom_range(0, 255));
      2: ctr = ($urandom_range(0, 1) != 0) ? 255 : int'($urandom_range(0, 2));
      default: ctr = int'($urandom_range(0, 255));
    endcase
    w.center_pixel = lbpc_pkg::PIX_W'(ctr);
    for (int k = 0; k < lbpc_pkg::NBR; k++) begin
      if (mode == 1) begin
        v = ctr + int'($urandom_range(0, 6)) - 3;
        v = (v < 0) ? 0 : (v > 255) ? 255 : v;
      end else begin
        v = int'($urandom_range(0, 255));
      end
      w[(lbpc_pkg::NBR-1-k)*lbpc_pkg::PIX_W +: lbpc_pkg::PIX_W] = lbpc_pkg::PIX_W'(v);
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_window(input lbpc_pkg::win_t w);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        window_valid <= 1'b0;
        @(posedge clk);
      end
    end
    window_valid <= 1'b1;
    window       <= w;
    do @(posedge clk); while (!window_ready);
    pending_results.insert(pending_results.size(), lbpc_expected(w));
  endtask

  task automatic wait_drained();
    window_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  always @(posedge clk) begin
    lbpc_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat, lbp_code", int'(result.lbp_code), -1);
      end else begin
        want = pending_results.pop_front();
        if (result.lbp_code !== want.lbp_code) begin
          report_mismatch("lbp_code", int'(result.lbp_code), int'(want.lbp_code));
        end
        if (result.contrast_q8 !== want.contrast_q8) begin
          report_mismatch("contrast_q8", int'(result.contrast_q8), int'(want.contrast_q8));
        end
      end
    end
    result_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic test_directed();
    lbpc_pkg::win_t w;
    send_window(uniform_window(0, 0));
    send_window(uniform_window(255, 255));
    send_window(uniform_window(0, 255));
    send_window(uniform_window(255, 0));
    send_window(uniform_window(255, 254));
    w = uniform_window(1, 0);
    for (int k = 0; k < lbpc_pkg::NBR; k += 2) begin
      w[(lbpc_pkg::NBR-1-k)*lbpc_pkg::PIX_W +: lbpc_pkg::PIX_W] = 8'd255;
    end
    send_window(w);
    for (int k = 0; k < lbpc_pkg::NBR; k++) begin
      w = uniform_window(100, 50);
      w[(lbpc_pkg::NBR-1-k)*lbpc_pkg::PIX_W +: lbpc_pkg::PIX_W] = 8'd200;
      send_window(w);
    end
    for (int k = 0; k < lbpc_pkg::NBR; k += lbpc_pkg::NBR - 1) begin
      w = uniform_window(100, 150);
      w[(lbpc_pkg::NBR-1-k)*lbpc_pkg::PIX_W +: lbpc_pkg::PIX_W] = 8'd99;
      send_window(w);
    end
    w = uniform_window(128, 127);
    w.pix_right = 8'd128;
    send_window(w);
    w = '{center_pixel: 8'd10, pix_top_left: 8'd11, pix_top: 8'd12, pix_top_right: 8'd200,
          pix_left: 8'd9, pix_right: 8'd3, pix_bottom_left: 8'd1, pix_bottom: 8'd0,
          pix_bottom_right: 8'd7};
    send_window(w);
    w = '{center_pixel: 8'd5, pix_top_left: 8'd255, pix_top: 8'd254, pix_top_right: 8'd253,
          pix_left: 8'd252, pix_right: 8'd251, pix_bottom_left: 8'd250, pix_bottom: 8'd249,
          pix_bottom_right: 8'd4};
    send_window(w);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_window(random_window(int'($urandom_range(0, 2))));
    end
  endtask

  task automatic test_drain_pause();
    for (int n = 0; n < 3; n++) begin
      for (int i = 0; i < 10; i++) begin
        send_window(random_window(int'($urandom_range(0, 2))));
      end
      wait_drained();
    end
  endtask

  task automatic test_back_to_back(input int count);
    steady = 1'b1;
    for (int i = 0; i < count; i++) begin
      send_window(random_window(int'($urandom_range(0, 2))));
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(700);
    test_drain_pause();
    test_back_to_back(200);
    test_random(700);
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/lbpc_pkg.sv
hdl/lbp_contrast_3x3.sv
tb/sv/lbp_contrast_3x3_tb.sv
